// ----- rtl/core/bbc_pkg.sv -----
package bbc_pkg;

    // Fixed word widths
    localparam int DATA_BITS      = 24;
    localparam int CFG_INDEX_BITS = 4;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF    = 18;
    localparam int COEF_FRAC_BITS_DEF = 22;

    // Terms per biquad section (b0, b1, b2, a1, a2) and the step counter width
    localparam int TERMS     = 5;
    localparam int STEP_BITS = 3;

    // Saturation limits
    localparam logic signed [DATA_BITS-1:0] DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_B0 = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_B1 = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_A1 = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_A2 = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_B0 = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_B1 = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_A1 = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_A2 = 4'd7;

    // Term indexes within a section
    localparam logic [STEP_BITS-1:0] TERM_B0 = 3'd0;
    localparam logic [STEP_BITS-1:0] TERM_B1 = 3'd1;
    localparam logic [STEP_BITS-1:0] TERM_B2 = 3'd2;
    localparam logic [STEP_BITS-1:0] TERM_A1 = 3'd3;
    localparam logic [STEP_BITS-1:0] TERM_A2 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HP,
        ST_HP_DONE,
        ST_LP,
        ST_LP_DONE
    } state_t;

    // Controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;     // load product register
        logic sub;        // product is subtracted (feedback term)
        logic acc_en;     // accumulate product register
        logic acc_first;  // first product of a section: restart the sum
    } mac_ctrl_t;

endpackage

// ----- rtl/core/biquad_bandpass_cascade_unit.sv -----
// Channel   Handshake              Word
// ------    ---------------------  -----------------------------------------
// input     in_valid / in_ready    sample  (SAMPLE_BITS, unsigned)
// output    out_valid / out_ready  filtered (24, signed), clipped (1)
// config    cfg_valid / cfg_ready  cfg_index (4), cfg_data (24, signed)
//
// A word is accepted in the idle state and loaded into the output register
// in the low-pass done state: each section runs 5 products through one shared
// multiplier and accumulator, with the product register between them, and
// rounds and saturates its sum in its done state. The input is taken again
// the cycle after the result is loaded.
// Reset clears coefficients, filter history and the output valid.
// A stalled output holds the last section in its done state; the next input
// is accepted once the block is back in idle after the result is loaded.
module biquad_bandpass_cascade_unit #(
    parameter int SAMPLE_BITS    = bbc_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bbc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [SAMPLE_BITS-1:0]                    sample,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [bbc_pkg::DATA_BITS-1:0]      filtered,
    output logic                                      clipped,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [bbc_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic signed [bbc_pkg::DATA_BITS-1:0]      cfg_data
);

    // Operand must hold a zero-extended sample and a signed 24-bit history value
    localparam int OPER_BITS = (SAMPLE_BITS + 1 > bbc_pkg::DATA_BITS) ?
                               SAMPLE_BITS + 1 : bbc_pkg::DATA_BITS;
    // Five products plus rounding headroom
    localparam int ACC_BITS  = bbc_pkg::DATA_BITS + OPER_BITS + 3;
    localparam logic [bbc_pkg::STEP_BITS-1:0] STEP_LAST = bbc_pkg::STEP_BITS'(bbc_pkg::TERMS);

    bbc_pkg::state_t state_reg;
    bbc_pkg::state_t state_next;
    logic [bbc_pkg::STEP_BITS-1:0] step_reg;
    logic [bbc_pkg::STEP_BITS-1:0] step_next;
    bbc_pkg::mac_ctrl_t mac_ctrl;

    // Coefficients
    logic signed [bbc_pkg::DATA_BITS-1:0] hp_b0_reg, hp_b1_reg, hp_a1_reg, hp_a2_reg;
    logic signed [bbc_pkg::DATA_BITS-1:0] lp_b0_reg, lp_b1_reg, lp_a1_reg, lp_a2_reg;

    // Filter history; low-pass input history is the high-pass output history
    logic [SAMPLE_BITS-1:0]               in_prev1_reg, in_prev2_reg;
    logic signed [bbc_pkg::DATA_BITS-1:0] mid_prev1_reg, mid_prev2_reg;
    logic signed [bbc_pkg::DATA_BITS-1:0] out_prev1_reg, out_prev2_reg;

    // Current word
    logic [SAMPLE_BITS-1:0]               x_reg;
    logic signed [bbc_pkg::DATA_BITS-1:0] mid_reg;
    logic                                 clip_reg;

    // Output register
    logic                                 out_valid_reg;
    logic signed [bbc_pkg::DATA_BITS-1:0] filtered_reg;
    logic                                 clipped_reg;

    logic signed [bbc_pkg::DATA_BITS-1:0] mac_coef;
    logic signed [OPER_BITS-1:0]          mac_oper;
    logic signed [bbc_pkg::DATA_BITS-1:0] mac_y;
    logic                                 mac_sat;
    logic                                 lp_sel;
    logic                                 in_take;
    logic                                 hp_capture;
    logic                                 lp_capture;

    assign in_ready  = (state_reg == bbc_pkg::ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign clipped   = clipped_reg;
    assign lp_sel    = (state_reg == bbc_pkg::ST_LP);

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbc_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        mac_ctrl.mul_en    = 1'b0;
        mac_ctrl.sub       = 1'b0;
        mac_ctrl.acc_en    = 1'b0;
        mac_ctrl.acc_first = 1'b0;
        hp_capture         = 1'b0;
        lp_capture         = 1'b0;
        unique case (state_reg)
            bbc_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = bbc_pkg::ST_HP;
                end
            end
            bbc_pkg::ST_HP, bbc_pkg::ST_LP:
            begin
                // Issue a product on steps 0..4, sum the registered product on steps 1..5
                mac_ctrl.mul_en    = (step_reg != STEP_LAST);
                mac_ctrl.sub       = (step_reg >= bbc_pkg::TERM_A1);
                mac_ctrl.acc_en    = (step_reg != '0);
                mac_ctrl.acc_first = (step_reg == bbc_pkg::STEP_BITS'(1));
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = (state_reg == bbc_pkg::ST_HP) ?
                                 bbc_pkg::ST_HP_DONE : bbc_pkg::ST_LP_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            bbc_pkg::ST_HP_DONE:
            begin
                hp_capture = 1'b1;
                state_next = bbc_pkg::ST_LP;
            end
            bbc_pkg::ST_LP_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    lp_capture = 1'b1;
                    state_next = bbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbc_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Term select: b0*x0 + b1*x1 + b0*x2 - a1*y1 - a2*y2
    //------------------------------------------------------------------
    always_comb
    begin
        case (step_reg)
            bbc_pkg::TERM_B0:
            begin
                mac_coef = lp_sel ? lp_b0_reg : hp_b0_reg;
                mac_oper = lp_sel ? OPER_BITS'(mid_reg) : OPER_BITS'({1'b0, x_reg});
            end
            bbc_pkg::TERM_B1:
            begin
                mac_coef = lp_sel ? lp_b1_reg : hp_b1_reg;
                mac_oper = lp_sel ? OPER_BITS'(mid_prev1_reg) :
                                    OPER_BITS'({1'b0, in_prev1_reg});
            end
            bbc_pkg::TERM_B2:
            begin
                mac_coef = lp_sel ? lp_b0_reg : hp_b0_reg;
                mac_oper = lp_sel ? OPER_BITS'(mid_prev2_reg) :
                                    OPER_BITS'({1'b0, in_prev2_reg});
            end
            bbc_pkg::TERM_A1:
            begin
                mac_coef = lp_sel ? lp_a1_reg : hp_a1_reg;
                mac_oper = lp_sel ? OPER_BITS'(out_prev1_reg) : OPER_BITS'(mid_prev1_reg);
            end
            bbc_pkg::TERM_A2:
            begin
                mac_coef = lp_sel ? lp_a2_reg : hp_a2_reg;
                mac_oper = lp_sel ? OPER_BITS'(out_prev2_reg) : OPER_BITS'(mid_prev2_reg);
            end
            default:
            begin
                mac_coef = '0;
                mac_oper = '0;
            end
        endcase
    end

    bbc_mac #(
        .OPER_BITS (OPER_BITS),
        .ACC_BITS  (ACC_BITS),
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (mac_coef),
        .oper  (mac_oper),
        .y     (mac_y),
        .sat   (mac_sat)
    );

    //------------------------------------------------------------------
    // Coefficient registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_b0_reg <= '0;
            hp_b1_reg <= '0;
            hp_a1_reg <= '0;
            hp_a2_reg <= '0;
            lp_b0_reg <= '0;
            lp_b1_reg <= '0;
            lp_a1_reg <= '0;
            lp_a2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bbc_pkg::REG_HP_B0: hp_b0_reg <= cfg_data;
                bbc_pkg::REG_HP_B1: hp_b1_reg <= cfg_data;
                bbc_pkg::REG_HP_A1: hp_a1_reg <= cfg_data;
                bbc_pkg::REG_HP_A2: hp_a2_reg <= cfg_data;
                bbc_pkg::REG_LP_B0: lp_b0_reg <= cfg_data;
                bbc_pkg::REG_LP_B1: lp_b1_reg <= cfg_data;
                bbc_pkg::REG_LP_A1: lp_a1_reg <= cfg_data;
                bbc_pkg::REG_LP_A2: lp_a2_reg <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    //------------------------------------------------------------------
    // Word registers (payload, no reset)
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= sample;
        end
        if (hp_capture)
        begin
            mid_reg  <= mac_y;
            clip_reg <= mac_sat;
        end
        if (lp_capture)
        begin
            filtered_reg <= mac_y;
            clipped_reg  <= clip_reg || mac_sat;
        end
    end

    //------------------------------------------------------------------
    // History shifts once both sections are done
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prev1_reg  <= '0;
            in_prev2_reg  <= '0;
            mid_prev1_reg <= '0;
            mid_prev2_reg <= '0;
            out_prev1_reg <= '0;
            out_prev2_reg <= '0;
        end
        else if (lp_capture)
        begin
            in_prev2_reg  <= in_prev1_reg;
            in_prev1_reg  <= x_reg;
            mid_prev2_reg <= mid_prev1_reg;
            mid_prev1_reg <= mid_reg;
            out_prev2_reg <= out_prev1_reg;
            out_prev1_reg <= mac_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (lp_capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_out_from_lp_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bbc_pkg::ST_LP_DONE))
        else $error("output word loaded outside the low-pass done step");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("term step counter out of range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (hp_capture || lp_capture) && mac_sat |->
            (mac_y == bbc_pkg::DATA_MAX || mac_y == bbc_pkg::DATA_MIN))
        else $error("saturated section result is not a limit value");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        lp_capture |-> (!out_valid_reg || out_ready))
        else $error("pending output word overwritten");

endmodule

// ----- rtl/core/bbc_mac.sv -----
module bbc_mac #(
    parameter int OPER_BITS = 25,
    parameter int ACC_BITS  = 52,
    parameter int FRAC_BITS = 22
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bbc_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [bbc_pkg::DATA_BITS-1:0] coef,
    input  logic signed [OPER_BITS-1:0]          oper,
    output logic signed [bbc_pkg::DATA_BITS-1:0] y,
    output logic                                 sat
);

    localparam int PROD_BITS = bbc_pkg::DATA_BITS + OPER_BITS;
    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(64'd1 << (FRAC_BITS - 1));

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic                        sub_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  acc_base;
    logic signed [ACC_BITS-1:0]  rounded;
    logic signed [ACC_BITS-1:0]  shifted;
    logic [ACC_BITS-bbc_pkg::DATA_BITS:0] upper;

    assign prod_next = coef * oper;

    always_comb
    begin
        acc_base = ctrl.acc_first ? '0 : acc_reg;
        if (sub_reg)
        begin
            acc_next = acc_base - ACC_BITS'(prod_reg);
        end
        else
        begin
            acc_next = acc_base + ACC_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            sub_reg  <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                prod_reg <= prod_next;
                sub_reg  <= ctrl.sub;
            end
            if (ctrl.acc_en)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Round half up, floor shift, saturate to the output word
    always_comb
    begin
        rounded = acc_reg + HALF;
        shifted = rounded >>> FRAC_BITS;
        upper   = shifted[ACC_BITS-1:bbc_pkg::DATA_BITS-1];
        sat     = !((&upper) || !(|upper));
        if (sat)
        begin
            y = shifted[ACC_BITS-1] ? bbc_pkg::DATA_MIN : bbc_pkg::DATA_MAX;
        end
        else
        begin
            y = shifted[bbc_pkg::DATA_BITS-1:0];
        end
    end

endmodule

// ----- tb/biquad_bandpass_cascade_unit_tb.sv -----
module biquad_bandpass_cascade_unit_tb;

    localparam int SMP_BITS       = bbc_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC_BITS      = bbc_pkg::COEF_FRAC_BITS_DEF;
    localparam int DATA_BITS      = bbc_pkg::DATA_BITS;
    localparam int CFG_INDEX_BITS = bbc_pkg::CFG_INDEX_BITS;

    // Q2.22 one, and bounds used for well-behaved random sections
    localparam int Q_ONE    = 1 << FRAC_BITS;
    localparam int POLE_LIM = (Q_ONE / 10) * 9;   // |a2| below 0.9
    localparam int FF_LIM   = Q_ONE / 8;          // |b| at most 0.125

    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int DRAIN_CYCLES    = 20;          // extra wait once all results are back
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [SMP_BITS-1:0] SMP_MAX = {SMP_BITS{1'b1}};

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = bbc_pkg::REG_LP_A2 + 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED  = {CFG_INDEX_BITS{1'b1}};

    typedef struct {
        logic signed [DATA_BITS-1:0] hp_b0, hp_b1, hp_a1, hp_a2;
        logic signed [DATA_BITS-1:0] lp_b0, lp_b1, lp_a1, lp_a2;
    } coef_set_t;

    typedef struct {
        logic signed [DATA_BITS-1:0] filtered;
        logic                        clipped;
    } bp_result_t;

    // Output-side backpressure styles
    typedef enum {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_LONG
    } stall_mode_t;

    // ------------------------------------------------------------------
    // DUT ports. Everything the bench drives starts at a known value.
    // ------------------------------------------------------------------
    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic [SMP_BITS-1:0]         sample    = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [DATA_BITS-1:0] filtered;
    logic                        clipped;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic signed [DATA_BITS-1:0] cfg_data  = '0;

    biquad_bandpass_cascade_unit #(
        .SAMPLE_BITS    (SMP_BITS),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .clipped   (clipped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Filter mirror: coefficient shadow plus the six history words.
    // The low-pass input history is the high-pass output history, so
    // only hp_hist* exists for it.
    // ------------------------------------------------------------------
    coef_set_t                   coef_shadow = '{default: '0};
    logic [SMP_BITS-1:0]         x_hist1 = '0, x_hist2 = '0;
    logic signed [DATA_BITS-1:0] hp_hist1 = '0, hp_hist2 = '0;
    logic signed [DATA_BITS-1:0] lp_hist1 = '0, lp_hist2 = '0;

    bp_result_t expected_q[$];

    int n_errors    = 0;
    int n_results   = 0;
    int cycle_count = 0;

    // Sender burst shaping
    int burst_left = 0;
    int burst_max  = 1;
    int gap_max    = 0;
    int pulse_level = 0;

    // Receiver stall shaping
    stall_mode_t stall_mode  = STALL_NONE;
    int          pat_period  = 4;
    int          pat_on      = 2;
    int          pat_phase   = 0;
    int          hold_cnt    = 0;
    logic        hold_level  = 1'b1;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // One biquad section, direct form I, b2 taken equal to b0.
    // Sum is exact in 64 bits; +half then arithmetic shift gives
    // round-to-nearest with ties toward +inf; then 24-bit saturation.
    // ------------------------------------------------------------------
    function automatic logic signed [DATA_BITS-1:0] biquad_section(
        input  longint b0, b1, a1, a2,
        input  longint x0, x1, x2, y1, y2,
        output logic   sat
    );
        longint acc;
        longint y;
        acc = b0 * x0 + b1 * x1 + b0 * x2 - a1 * y1 - a2 * y2
            + (longint'(1) <<< (FRAC_BITS - 1));
        y   = acc >>> FRAC_BITS;
        sat = 1'b0;
        if (y > longint'(bbc_pkg::DATA_MAX))
        begin
            sat = 1'b1;
            y   = longint'(bbc_pkg::DATA_MAX);
        end
        else if (y < longint'(bbc_pkg::DATA_MIN))
        begin
            sat = 1'b1;
            y   = longint'(bbc_pkg::DATA_MIN);
        end
        return y[DATA_BITS-1:0];
    endfunction

    // Runs one accepted sample through both sections, queues the result.
    function automatic void predict_bandpass(input logic [SMP_BITS-1:0] x);
        logic signed [DATA_BITS-1:0] mid;
        logic signed [DATA_BITS-1:0] res;
        logic                        sat_hp;
        logic                        sat_lp;
        bp_result_t                  r;
        mid = biquad_section(coef_shadow.hp_b0, coef_shadow.hp_b1,
                             coef_shadow.hp_a1, coef_shadow.hp_a2,
                             longint'(x), longint'(x_hist1), longint'(x_hist2),
                             hp_hist1, hp_hist2, sat_hp);
        res = biquad_section(coef_shadow.lp_b0, coef_shadow.lp_b1,
                             coef_shadow.lp_a1, coef_shadow.lp_a2,
                             mid, hp_hist1, hp_hist2,
                             lp_hist1, lp_hist2, sat_lp);
        x_hist2  = x_hist1;
        x_hist1  = x;
        hp_hist2 = hp_hist1;
        hp_hist1 = mid;
        lp_hist2 = lp_hist1;
        lp_hist1 = res;
        r.filtered = res;
        r.clipped  = sat_hp | sat_lp;
        expected_q.push_back(r);
    endfunction

    function automatic void note_error();
        n_errors++;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted output word against the oldest
    // expectation. Only the first ten problems are printed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bp_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                note_error();
                if (n_errors <= 10)
                    $display("unexpected word %0d: filtered %0d clipped %0b",
                             n_results, filtered, clipped);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (filtered !== exp_r.filtered || clipped !== exp_r.clipped)
                begin
                    note_error();
                    if (n_errors <= 10)
                        $display({"mismatch word %0d: filtered exp %0d got %0d, ",
                                  "clipped exp %0b got %0b"},
                                 n_results, exp_r.filtered, filtered,
                                 exp_r.clipped, clipped);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver backpressure. Each mode gives a different stall texture;
    // STALL_NONE gives stretches with no stall at all.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        case (stall_mode)
            STALL_NONE:   out_ready <= 1'b1;
            STALL_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
            STALL_PATTERN:
            begin
                pat_phase = (pat_phase + 1) % pat_period;
                out_ready <= (pat_phase < pat_on);
            end
            default:
            begin
                // long holds low, shorter holds high
                if (hold_cnt == 0)
                begin
                    hold_level = ~hold_level;
                    hold_cnt   = hold_level ? $urandom_range(1, 8) : $urandom_range(1, 30);
                end
                else
                begin
                    hold_cnt--;
                end
                out_ready <= hold_level;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Channel tasks. All are entered just after a rising edge; inputs
    // change by NBA there, and handshakes are judged on pre-edge values.
    // ------------------------------------------------------------------

    // Config write; cfg_valid stays high across back-to-back writes.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic signed [DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bbc_pkg::REG_HP_B0: coef_shadow.hp_b0 = data;
            bbc_pkg::REG_HP_B1: coef_shadow.hp_b1 = data;
            bbc_pkg::REG_HP_A1: coef_shadow.hp_a1 = data;
            bbc_pkg::REG_HP_A2: coef_shadow.hp_a2 = data;
            bbc_pkg::REG_LP_B0: coef_shadow.lp_b0 = data;
            bbc_pkg::REG_LP_B1: coef_shadow.lp_b1 = data;
            bbc_pkg::REG_LP_A1: coef_shadow.lp_a1 = data;
            bbc_pkg::REG_LP_A2: coef_shadow.lp_a2 = data;
            default: ;  // unused index: dropped by the block
        endcase
    endtask

    // Loads a full coefficient set; optionally pokes an unused index too.
    task automatic load_coefs(input coef_set_t cs, input bit poke_unused);
        write_reg(bbc_pkg::REG_HP_B0, cs.hp_b0);
        write_reg(bbc_pkg::REG_HP_B1, cs.hp_b1);
        write_reg(bbc_pkg::REG_HP_A1, cs.hp_a1);
        write_reg(bbc_pkg::REG_HP_A2, cs.hp_a2);
        if (poke_unused)
            write_reg(CFG_INDEX_BITS'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      DATA_BITS'($urandom()));
        write_reg(bbc_pkg::REG_LP_B0, cs.lp_b0);
        write_reg(bbc_pkg::REG_LP_B1, cs.lp_b1);
        write_reg(bbc_pkg::REG_LP_A1, cs.lp_a1);
        write_reg(bbc_pkg::REG_LP_A2, cs.lp_a2);
        cfg_valid <= 1'b0;
    endtask

    // Sends one sample word. Gaps are inserted between bursts only, so
    // valid never drops while a word waits for acceptance.
    task automatic send_sample(input logic [SMP_BITS-1:0] x);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        in_valid <= 1'b1;
        sample   <= x;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        predict_bandpass(x);
    endtask

    // Drops valid and waits until every queued result has come back,
    // then a further drain wait so the block is surely idle.
    task automatic wait_drained();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------
    function automatic logic [SMP_BITS-1:0] next_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return SMP_BITS'($urandom());
        if (kind < 7)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return SMP_MAX;
                default: return {{(SMP_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, SMP_BITS-1);
            endcase
        end
        // slow drifting level, like a pulse waveform on a DC offset
        pulse_level = pulse_level + $urandom_range(0, 4000) - 2000;
        if (pulse_level < 0)
            pulse_level = 0;
        if (pulse_level > int'(SMP_MAX))
            pulse_level = int'(SMP_MAX);
        return pulse_level[SMP_BITS-1:0];
    endfunction

    // Inside the stability triangle, small feed-forward gain
    function automatic void stable_section(output logic signed [DATA_BITS-1:0] b0, b1, a1, a2);
        int a2_v;
        int a1_lim;
        a2_v   = int'($urandom_range(0, 2 * POLE_LIM)) - POLE_LIM;
        a1_lim = ((Q_ONE + a2_v) / 10) * 9;
        a2     = DATA_BITS'(a2_v);
        a1     = DATA_BITS'(int'($urandom_range(0, 2 * a1_lim)) - a1_lim);
        b0     = DATA_BITS'(int'($urandom_range(0, 2 * FF_LIM)) - FF_LIM);
        b1     = DATA_BITS'(int'($urandom_range(0, 2 * FF_LIM)) - FF_LIM);
    endfunction

    function automatic logic signed [DATA_BITS-1:0] extreme_coef();
        case ($urandom_range(0, 2))
            0:       return bbc_pkg::DATA_MAX;
            1:       return bbc_pkg::DATA_MIN;
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Coefficients are zero out of reset: everything filters to zero.
    task automatic test_after_reset();
        send_sample('0);
        send_sample(SMP_MAX);
        wait_drained();
    endtask

    // b0 = 1.0 in both sections: mid = x[n] + x[n-2], out = mid + mid[n-2].
    // Walks the sample word through its extremes and bit patterns.
    task automatic test_unity_path();
        coef_set_t cs;
        cs       = '{default: '0};
        cs.hp_b0 = DATA_BITS'(Q_ONE);
        cs.lp_b0 = DATA_BITS'(Q_ONE);
        load_coefs(cs, 1'b0);
        send_sample('0);
        send_sample(SMP_MAX);
        send_sample({(SMP_BITS/2){2'b10}});
        send_sample({(SMP_BITS/2){2'b01}});
        send_sample({{(SMP_BITS-1){1'b0}}, 1'b1});
        send_sample({1'b1, {(SMP_BITS-1){1'b0}}});
        wait_drained();
    endtask

    // Full-scale coefficients drive both sections into the rails, in both
    // directions; the clipped high-pass value feeds the low-pass section.
    task automatic test_saturation();
        coef_set_t cs;
        cs.hp_b0 = bbc_pkg::DATA_MAX;
        cs.hp_b1 = bbc_pkg::DATA_MAX;
        cs.hp_a1 = bbc_pkg::DATA_MIN;
        cs.hp_a2 = '0;
        cs.lp_b0 = bbc_pkg::DATA_MIN;
        cs.lp_b1 = '0;
        cs.lp_a1 = '0;
        cs.lp_a2 = bbc_pkg::DATA_MAX;
        load_coefs(cs, 1'b0);
        stall_mode = STALL_RANDOM;
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample('0);
        send_sample(SMP_MAX);
        send_sample('0);
        send_sample('0);
        wait_drained();
    endtask

    // Writes to indexes past the register map must leave the filter as is.
    task automatic test_unused_index();
        coef_set_t cs;
        cs       = '{default: '0};
        cs.hp_b0 = DATA_BITS'(Q_ONE);
        cs.hp_b1 = DATA_BITS'(-Q_ONE);
        cs.lp_b0 = DATA_BITS'(Q_ONE / 2);
        load_coefs(cs, 1'b0);
        @(posedge clk);
        write_reg(REG_FIRST_UNUSED, bbc_pkg::DATA_MAX);
        write_reg(REG_LAST_UNUSED, bbc_pkg::DATA_MIN);
        cfg_valid <= 1'b0;
        send_sample(SMP_MAX);
        send_sample('0);
        send_sample({(SMP_BITS/2){2'b10}});
        wait_drained();
    endtask

    // Phases of random words, each with its own coefficient set, sender
    // burst shape and receiver stall style.
    task automatic test_random_phases();
        coef_set_t cs;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 4)
                1:
                begin
                    cs.hp_b0 = DATA_BITS'($urandom());
                    cs.hp_b1 = DATA_BITS'($urandom());
                    cs.hp_a1 = DATA_BITS'($urandom());
                    cs.hp_a2 = DATA_BITS'($urandom());
                    cs.lp_b0 = DATA_BITS'($urandom());
                    cs.lp_b1 = DATA_BITS'($urandom());
                    cs.lp_a1 = DATA_BITS'($urandom());
                    cs.lp_a2 = DATA_BITS'($urandom());
                end
                3:
                begin
                    cs.hp_b0 = extreme_coef();
                    cs.hp_b1 = extreme_coef();
                    cs.hp_a1 = extreme_coef();
                    cs.hp_a2 = extreme_coef();
                    cs.lp_b0 = extreme_coef();
                    cs.lp_b1 = extreme_coef();
                    cs.lp_a1 = extreme_coef();
                    cs.lp_a2 = extreme_coef();
                end
                default:
                begin
                    stable_section(cs.hp_b0, cs.hp_b1, cs.hp_a1, cs.hp_a2);
                    stable_section(cs.lp_b0, cs.lp_b1, cs.lp_a1, cs.lp_a2);
                end
            endcase
            load_coefs(cs, p % 2 == 1);

            stall_mode = stall_mode_t'(p % 4);
            pat_period = $urandom_range(2, 9);
            pat_on     = $urandom_range(1, pat_period - 1);
            gap_max    = (p % 3 == 0) ? 0 : $urandom_range(1, 20);
            burst_max  = $urandom_range(1, 12);

            repeat (ITEMS_PER_PHASE) send_sample(next_sample());
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: one reset, directed tests, random phases, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_unity_path();
        test_saturation();
        test_unused_index();
        test_random_phases();

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- biquad_bandpass_cascade_unit.f -----
rtl/core/bbc_pkg.sv
rtl/core/bbc_mac.sv
rtl/core/biquad_bandpass_cascade_unit.sv
tb/biquad_bandpass_cascade_unit_tb.sv
